// ===== rtl/core/mavg_pkg.sv =====
// Shared constants, types and register codes for the four-channel moving average unit.
`timescale 1ns / 1ps
`default_nettype none

package mavg_pkg;

	// Window and data widths.
	localparam int WINDOW_SAMPLES = 8;
	localparam int NUM_CH         = 4;
	localparam int SAMPLE_W       = 10;
	localparam int SUM_W          = 16;
	localparam int EDGE_W         = 4;
	localparam int SLOT_W         = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
	localparam int RING_W         = NUM_CH * SAMPLE_W;

	// Exact division of a running sum by the window length: multiply by a rounded-up
	// reciprocal and keep the upper bits.
	localparam int RECIP_SHIFT = SUM_W + SLOT_W;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) /
		64'(WINDOW_SAMPLES));

	// Result queue.
	localparam int OUTQ_DEPTH = 8;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OCC_W      = $clog2(OUTQ_DEPTH + 1);

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SAMPLE_W;
	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESHOLD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_WHITE_LEVEL   = CFG_IDX_W'(1);
	localparam logic [SAMPLE_W-1:0]  THRESHOLD_RESET        = SAMPLE_W'(512);
	localparam logic                 WHITE_LEVEL_RESET      = 1'b1;

	typedef logic [SAMPLE_W-1:0]              sample_t;
	typedef logic [SUM_W-1:0]                 sum_t;
	typedef logic [SLOT_W-1:0]                slot_t;
	typedef logic [NUM_CH-1:0][SAMPLE_W-1:0]  samples_t;
	typedef logic [NUM_CH-1:0][SUM_W-1:0]     sums_t;

	// Updated window sums leaving the ring stage.
	typedef struct packed {
		logic              valid;
		sums_t             sums;
		logic [EDGE_W-1:0] edge_levels;
	} sum_stage_t;

	// One finished result.
	typedef struct packed {
		samples_t          avg;
		logic [NUM_CH-1:0] near;
		logic [EDGE_W-1:0] white_mask;
		logic              any_edge;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mavg_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mavg_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mavg_ring.sv =====
// Sample ring read-modify-write stage and the four running window sums.
`timescale 1ns / 1ps
`default_nettype none

module mavg_ring
	import mavg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              mode,
	input  wire samples_t          samples,
	input  wire logic [EDGE_W-1:0] edge_levels,
	output sum_stage_t             sum_s2
);

	slot_t                slot_q;
	slot_t                slot_now;
	slot_t                slot_next;
	logic [WINDOW_SAMPLES-1:0] slot_written_q;

	logic                 valid_s1;
	slot_t                slot_s1;
	samples_t             samples_s1;
	logic [EDGE_W-1:0]    edge_s1;
	logic                 hit_s1;
	logic                 fwd_s1;
	samples_t             fwd_data_s1;

	logic [RING_W-1:0]    ram_rdata;
	samples_t             old_samples;
	sums_t                sum_q;
	sums_t                sum_new;

	// Restart forces slot zero; the slot then advances with wrap at the window length.
	assign slot_now  = mode ? '0 : slot_q;
	assign slot_next = (slot_now == SLOT_W'(WINDOW_SAMPLES - 1)) ? '0 : slot_now + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (accept) begin
			slot_q <= slot_next;
		end
	end

	// The ring memory: read the outgoing samples at acceptance, write the new ones in the following cycle.
	mavg_ram #(
		.WIDTH (RING_W),
		.DEPTH (WINDOW_SAMPLES)
	) u_ring_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (slot_s1),
		.wdata (samples_s1),
		.re    (accept),
		.raddr (slot_now),
		.rdata (ram_rdata)
	);

	// Per-slot written flags stand in for clearing the ring at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_written_q <= '0;
		end else if (valid_s1) begin
			slot_written_q[slot_s1] <= 1'b1;
		end
	end

	// Stage one registers; the forward flag catches a read of the slot written at the same edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				hit_s1 <= slot_written_q[slot_now];
				fwd_s1 <= valid_s1 && (slot_s1 == slot_now);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1     <= slot_now;
			samples_s1  <= samples;
			edge_s1     <= edge_levels;
			fwd_data_s1 <= samples_s1;
		end
	end

	// Outgoing samples: forwarded, read from memory, or zero for a slot never written.
	always_comb begin
		if (fwd_s1) begin
			old_samples = fwd_data_s1;
		end else if (hit_s1) begin
			old_samples = ram_rdata;
		end else begin
			old_samples = '0;
		end
	end

	// Running sums drop the outgoing sample and add the incoming one.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			sum_new[c] = sum_q[c] - SUM_W'(old_samples[c]) + SUM_W'(samples_s1[c]);
		end
	end

	// Stage two register and the running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			sum_s2 <= '0;
		end else begin
			sum_s2.valid <= valid_s1;
			if (valid_s1) begin
				sum_q              <= sum_new;
				sum_s2.sums        <= sum_new;
				sum_s2.edge_levels <= edge_s1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mavg_scale.sv =====
// Average by reciprocal multiply, threshold flags and edge mask.
`timescale 1ns / 1ps
`default_nettype none

module mavg_scale
	import mavg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sum_stage_t        sum_s2,
	input  wire sample_t           threshold,
	input  wire logic              white_level,
	output logic                   res_valid,
	output result_t                res
);

	logic                          valid_s3;
	logic [NUM_CH-1:0][PROD_W-1:0] prod_s3;
	logic [EDGE_W-1:0]             edge_s3;

	// One multiplier per channel, registered before the result is formed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= sum_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_s2.valid) begin
			for (int c = 0; c < NUM_CH; c++) begin
				prod_s3[c] <= PROD_W'(sum_s2.sums[c]) * PROD_W'(RECIP);
			end
			edge_s3 <= sum_s2.edge_levels;
		end
	end

	// Quotient bits, near flags and the white mask.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			res.avg[c]  = prod_s3[c][RECIP_SHIFT +: SAMPLE_W];
			res.near[c] = res.avg[c] > threshold;
		end
		res.white_mask = ~(edge_s3 ^ {EDGE_W{white_level}});
		res.any_edge   = |res.white_mask;
	end

	assign res_valid = valid_s3;

endmodule

`default_nettype wire

// ===== rtl/core/mavg_outq.sv =====
// Result queue that decouples the pipeline from the output handshake.
`timescale 1ns / 1ps
`default_nettype none

module mavg_outq
	import mavg_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	input  wire logic    pop_ready,
	output logic         pop_valid,
	output result_t      pop_data
);

	result_t              entry_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0]   wptr_q;
	logic [OUTQ_AW-1:0]   rptr_q;
	logic [OUTQ_AW:0]     count_q;
	logic                 pop;

	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;
	assign pop_data  = entry_q[rptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (OUTQ_AW + 1)'(push) - (OUTQ_AW + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/four_channel_moving_average_unit.sv =====
// Top level of the four-channel boxcar moving average unit with near and edge flags.
// Throughput: one item per cycle while in_ready stays high.
// Up to eight items may be in flight or queued before in_ready drops.
// Reset (arst_n low, asynchronous) clears sums, write slot, queue and per-slot written
// flags, so the ring reads as zero at once; no clearing pass is needed.
// Registers reset to threshold 512 and white level 1; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module four_channel_moving_average_unit
	import mavg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  mode,
	input  wire logic [SAMPLE_W-1:0]   sample_front_left,
	input  wire logic [SAMPLE_W-1:0]   sample_front_right,
	input  wire logic [SAMPLE_W-1:0]   sample_left,
	input  wire logic [SAMPLE_W-1:0]   sample_right,
	input  wire logic [EDGE_W-1:0]     edge_levels,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [SAMPLE_W-1:0]   avg_front_left,
	output logic      [SAMPLE_W-1:0]   avg_front_right,
	output logic      [SAMPLE_W-1:0]   avg_left,
	output logic      [SAMPLE_W-1:0]   avg_right,
	output logic                       near_front_left,
	output logic                       near_front_right,
	output logic                       near_left,
	output logic                       near_right,
	output logic      [EDGE_W-1:0]     edge_white_mask,
	output logic                       any_edge,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	sample_t      threshold_q;
	logic         white_level_q;
	logic         accept;
	logic         pop;
	logic [OCC_W-1:0] occ_q;
	samples_t     samples;
	sum_stage_t   sum_s2;
	logic         res_valid;
	result_t      res;
	result_t      out_res;

	// Configuration registers; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q   <= THRESHOLD_RESET;
			white_level_q <= WHITE_LEVEL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DISTANCE_THRESHOLD: threshold_q   <= cfg_data[SAMPLE_W-1:0];
				REG_EDGE_WHITE_LEVEL:   white_level_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Items in the pipeline plus queued results never exceed the queue depth.
	assign in_ready = (occ_q < OCC_W'(OUTQ_DEPTH));
	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(accept) - OCC_W'(pop);
		end
	end

	// Channel order: front left, front right, left, right.
	assign samples = {sample_right, sample_left, sample_front_right, sample_front_left};

	mavg_ring u_ring (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.mode        (mode),
		.samples     (samples),
		.edge_levels (edge_levels),
		.sum_s2      (sum_s2)
	);

	mavg_scale u_scale (
		.clk         (clk),
		.arst_n      (arst_n),
		.sum_s2      (sum_s2),
		.threshold   (threshold_q),
		.white_level (white_level_q),
		.res_valid   (res_valid),
		.res         (res)
	);

	mavg_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_ready (out_ready),
		.pop_valid (out_valid),
		.pop_data  (out_res)
	);

	// Result fields.
	assign avg_front_left   = out_res.avg[0];
	assign avg_front_right  = out_res.avg[1];
	assign avg_left         = out_res.avg[2];
	assign avg_right        = out_res.avg[3];
	assign near_front_left  = out_res.near[0];
	assign near_front_right = out_res.near[1];
	assign near_left        = out_res.near[2];
	assign near_right       = out_res.near[3];
	assign edge_white_mask  = out_res.white_mask;
	assign any_edge         = out_res.any_edge;

endmodule

`default_nettype wire
